// File: hdl/ncl1_pkg.sv
// Shared types and constants for the nearest-centroid L1 classifier.
package ncl1_pkg;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned CLS_W = 4;
   localparam int unsigned VAL_W = 16;
   localparam int unsigned Q_W = 24;
   localparam int unsigned SUM_W = 32;
   localparam int unsigned CSR_W = 16;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_TRAIN = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_TEST = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_NUM_CLASSES = 2'd0,
      REG_FEATURE_LEN = 2'd1,
      REG_SAMPLES = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [CLS_W-1:0] class_id;
      logic [VAL_W-1:0] feature_value;
   } req_type;

   typedef struct packed {
      logic [CLS_W-1:0] class_index;
      logic [Q_W-1:0] mean_distance;
      logic [CLS_W-1:0] best_class;
      logic last;
   } rsp_type;

   // Divider handshake between the sequencer and the shared divide unit.
   typedef struct packed {
      logic start;
      logic [SUM_W+7:0] dividend;
      logic [VAL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [Q_W-1:0] quotient;
   } div_rsp_type;
endpackage

// File: hdl/ncl1_if.sv
// Valid/ready stream interfaces for request and response channels.
interface ncl1_req_if;
   import ncl1_pkg::*;
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ncl1_rsp_if;
   import ncl1_pkg::*;
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/nearest_centroid_l1_classifier.sv
// Top level: sequencer around the sum and centroid memories and the divider.
// Nearest-centroid classifier with mean L1 distance, one feature element per
// req transfer. cmd selects clear, train element, finish or test element.
// Train: read, add and write the sum for the element. Test: one centroid read
// and one accumulate per class through the single centroid memory port.
// Finish: per class and element, a sum read, then the 41-bit serial divider.
// Final test element: one divide per class, then num_classes rsp transfers,
// last on the final one. Clear: a sweep over all MAX_CLASSES*MAX_FEATURES
// entries of the sum memory. Reset runs the same sweep; req stays not ready
// during it while csr writes are taken. A stalled rsp holds the block until
// the result is taken; the next request is accepted once the result sits in
// the output register.
module nearest_centroid_l1_classifier #(
   parameter int unsigned MAX_CLASSES = 16,
   parameter int unsigned MAX_FEATURES = 64
) (
   input logic clock,
   input logic reset,
   ncl1_req_if.sink req,
   ncl1_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [ncl1_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ncl1_pkg::CSR_W-1:0] csr_write_data
);
   import ncl1_pkg::*;
   localparam int unsigned CIW = $clog2(MAX_CLASSES);
   localparam int unsigned FIW = $clog2(MAX_FEATURES);
   localparam int unsigned AW = CIW + FIW;
   localparam int unsigned DEPTH = MAX_CLASSES * MAX_FEATURES;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE = 10'b0000000010,
      S_TR_RD = 10'b0000000100,
      S_TR_WR = 10'b0000001000,
      S_FN_RD = 10'b0000010000,
      S_FN_DIV = 10'b0000100000,
      S_TS_RD = 10'b0001000000,
      S_TS_ACC = 10'b0010000000,
      S_MN_DIV = 10'b0100000000,
      S_OUT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] ncls_ff;
   logic [6:0] flen_ff;
   logic [VAL_W-1:0] spc_ff;

   logic [SUM_W-1:0] sum_mem [DEPTH];
   logic [Q_W-1:0] cen_mem [DEPTH];
   logic [SUM_W-1:0] acc_ff [MAX_CLASSES];
   logic [SUM_W-1:0] sum_rd_ff;
   logic [Q_W-1:0] cen_rd_ff;

   logic sum_we, cen_we;
   logic [AW-1:0] sum_wa, sum_ra, cen_wa, cen_ra;
   logic [SUM_W-1:0] sum_wd;
   logic [Q_W-1:0] cen_wd;

   logic [AW:0] sweep_ff, sweep_in;
   logic [CIW:0] cls_ff, cls_in;
   logic [FIW:0] elem_ff, elem_in;
   logic [FIW:0] eidx_ff, eidx_in;
   logic [CIW-1:0] rcls_ff, rcls_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CIW:0] nc;
   logic [FIW:0] nf;
   logic [FIW:0] idx;
   logic acc_clr, acc_we;
   logic [SUM_W-1:0] acc_nx;
   logic [Q_W-1:0] mean_ff [MAX_CLASSES];
   logic mean_we;
   logic [CIW-1:0] best_ff, best_in;
   logic [Q_W-1:0] bmean_ff, bmean_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   div_req_type dreq;
   div_rsp_type drsp;
   logic [SUM_W:0] ssum;
   logic [Q_W-1:0] x, absdiff;
   logic [SUM_W:0] asum;

   ncl1_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      if (ncls_ff == 5'd0) nc = (CIW+1)'(1);
      else if (32'(ncls_ff) > MAX_CLASSES) nc = (CIW+1)'(MAX_CLASSES);
      else nc = (CIW+1)'(ncls_ff);
      if (flen_ff == 7'd0) nf = (FIW+1)'(1);
      else if (32'(flen_ff) > MAX_FEATURES) nf = (FIW+1)'(MAX_FEATURES);
      else nf = (FIW+1)'(flen_ff);
      idx = (eidx_ff >= nf) ? '0 : eidx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncls_ff <= 5'd10;
         flen_ff <= 7'd32;
         spc_ff <= VAL_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_NUM_CLASSES: ncls_ff <= csr_write_data[4:0];
            REG_FEATURE_LEN: flen_ff <= csr_write_data[6:0];
            REG_SAMPLES: spc_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      sum_rd_ff <= sum_mem[sum_ra];
      if (cen_we) cen_mem[cen_wa] <= cen_wd;
      cen_rd_ff <= cen_mem[cen_ra];
   end

   assign x = {val_ff, 8'd0};
   assign absdiff = (cen_rd_ff > x) ? cen_rd_ff - x : x - cen_rd_ff;
   assign asum = {1'b0, acc_ff[cls_ff[CIW-1:0]]} + (SUM_W+1)'(absdiff);
   assign acc_nx = asum[SUM_W] ? {SUM_W{1'b1}} : asum[SUM_W-1:0];
   assign ssum = {1'b0, sum_rd_ff} + (SUM_W+1)'(val_ff);

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      cls_in = cls_ff;
      elem_in = elem_ff;
      eidx_in = eidx_ff;
      rcls_in = rcls_ff;
      val_in = val_ff;
      best_in = best_ff;
      bmean_in = bmean_ff;
      rv_in = rv_ff;
      rsp_in = rsp_ff;
      sum_we = 1'b0;
      sum_wa = rcls_ff * MAX_FEATURES[AW-1:0] + AW'(elem_ff);
      sum_wd = ssum[SUM_W] ? {SUM_W{1'b1}} : ssum[SUM_W-1:0];
      sum_ra = AW'(rcls_ff) * AW'(MAX_FEATURES) + AW'(elem_ff);
      cen_we = 1'b0;
      cen_wa = AW'(cls_ff[CIW-1:0]) * AW'(MAX_FEATURES) + AW'(elem_ff);
      cen_wd = drsp.quotient;
      cen_ra = AW'(cls_ff[CIW-1:0]) * AW'(MAX_FEATURES) + AW'(elem_ff);
      acc_clr = 1'b0;
      acc_we = 1'b0;
      mean_we = 1'b0;
      dreq = '0;
      dreq.divisor = (spc_ff == '0) ? VAL_W'(1) : spc_ff;
      dreq.dividend = {sum_rd_ff, 8'd0};
      req.ready = 1'b0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            sum_we = 1'b1;
            sum_wa = sweep_ff[AW-1:0];
            sum_wd = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (AW+1)'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               val_in = req.payload.feature_value;
               rcls_in = CIW'(req.payload.class_id);
               elem_in = idx;
               cls_in = '0;
               case (req.payload.cmd)
                  CMD_CLEAR: begin
                     acc_clr = 1'b1;
                     eidx_in = '0;
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_TRAIN: begin
                     eidx_in = (idx + 1'b1 >= nf) ? '0 : idx + 1'b1;
                     if ((CIW+1)'(req.payload.class_id) < nc &&
                         32'(req.payload.class_id) < MAX_CLASSES)
                        state_in = S_TR_RD;
                  end
                  CMD_FINISH: begin
                     acc_clr = 1'b1;
                     eidx_in = '0;
                     elem_in = '0;
                     rcls_in = '0;
                     state_in = S_FN_RD;
                  end
                  default: state_in = S_TS_RD;
               endcase
            end
         end
         S_TR_RD: state_in = S_TR_WR;
         S_TR_WR: begin
            sum_we = 1'b1;
            state_in = S_IDLE;
         end
         S_FN_RD: begin
            // sum read for (rcls, elem) lands next cycle; start then
            state_in = S_FN_DIV;
            dreq.start = 1'b0;
            cls_in = (CIW+1)'(rcls_ff);
         end
         S_FN_DIV: begin
            if (cls_ff[CIW]) begin
               // first cycle in: kick the divider with fresh read data
               cls_in = {1'b0, cls_ff[CIW-1:0]};
            end
            if (drsp.done) begin
               cen_we = 1'b1;
               if (elem_ff + 1'b1 < nf) begin
                  elem_in = elem_ff + 1'b1;
                  state_in = S_FN_RD;
               end else if ((CIW+1)'(rcls_ff) + 1'b1 < nc) begin
                  elem_in = '0;
                  rcls_in = rcls_ff + 1'b1;
                  state_in = S_FN_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_TS_RD: state_in = S_TS_ACC;
         S_TS_ACC: begin
            acc_we = 1'b1;
            if (cls_ff + 1'b1 < nc) begin
               cls_in = cls_ff + 1'b1;
               state_in = S_TS_RD;
            end else if (elem_ff + 1'b1 < nf) begin
               eidx_in = elem_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               eidx_in = '0;
               // top bit marks the start cycle of a class divide
               cls_in = {1'b1, CIW'(0)};
               state_in = S_MN_DIV;
            end
         end
         S_MN_DIV: begin
            dreq.divisor = VAL_W'(nf);
            dreq.dividend = (SUM_W+8)'(acc_ff[cls_ff[CIW-1:0]]);
            if (cls_ff[CIW]) begin
               cls_in = {1'b0, cls_ff[CIW-1:0]};
               dreq.start = 1'b1;
            end
            if (drsp.done) begin
               mean_we = 1'b1;
               if (cls_ff == '0 || drsp.quotient < bmean_ff) begin
                  best_in = cls_ff[CIW-1:0];
                  bmean_in = drsp.quotient;
               end
               if (cls_ff + 1'b1 < nc) begin
                  cls_in = {1'b1, cls_ff[CIW-1:0] + 1'b1};
               end else begin
                  cls_in = '0;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rsp_in.class_index = CLS_W'(cls_ff);
               rsp_in.mean_distance = mean_ff[cls_ff[CIW-1:0]];
               rsp_in.best_class = CLS_W'(best_ff);
               rsp_in.last = (cls_ff + 1'b1 == nc);
               cls_in = cls_ff + 1'b1;
               if (cls_ff + 1'b1 == nc) begin
                  acc_clr = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // divider start for finish: in the cycle after the sum read issues
      if (state_ff == S_FN_DIV && cls_ff[CIW]) dreq.start = 1'b1;
      if (state_ff == S_FN_DIV) begin
         dreq.divisor = (spc_ff == '0) ? VAL_W'(1) : spc_ff;
         dreq.dividend = {sum_rd_ff, 8'd0};
         cen_wa = AW'(rcls_ff) * AW'(MAX_FEATURES) + AW'(elem_ff);
      end
      if (state_ff == S_FN_RD) cls_in = {1'b1, rcls_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         eidx_ff <= '0;
         cls_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         eidx_ff <= eidx_in;
         cls_ff <= cls_in;
         rv_ff <= rv_in;
      end
      elem_ff <= elem_in;
      rcls_ff <= rcls_in;
      val_ff <= val_in;
      best_ff <= best_in;
      bmean_ff <= bmean_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
         if (reset || acc_clr) acc_ff[i] <= '0;
         else if (acc_we && cls_ff[CIW-1:0] == CIW'(i)) acc_ff[i] <= acc_nx;
         if (mean_we && cls_ff[CIW-1:0] == CIW'(i)) mean_ff[i] <= drsp.quotient;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;
endmodule

// File: hdl/ncl1_div.sv
// Restoring divider, one quotient bit per cycle, rounds half up, saturates to Q_W.
module ncl1_div (
   input logic clock,
   input logic reset,
   input ncl1_pkg::div_req_type req,
   output ncl1_pkg::div_rsp_type rsp
);
   import ncl1_pkg::*;
   // one spare bit so the rounding add on a full-scale dividend cannot wrap
   localparam int unsigned NW = SUM_W + 9;
   localparam int unsigned CW = $clog2(NW + 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [VAL_W:0] rem_ff, rem_in;
   logic [VAL_W-1:0] den_ff, den_in;
   logic [VAL_W:0] trial;
   logic [VAL_W:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      shifted = {rem_ff[VAL_W-1:0], num_ff[NW-1]};
      trial = shifted - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = CW'(NW);
         num_in = {1'b0, req.dividend} + NW'(req.divisor >> 1);
         rem_in = '0;
         den_in = req.divisor;
      end else if (busy_ff) begin
         if (!trial[VAL_W]) begin
            rem_in = trial;
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = (|num_ff[NW-1:Q_W]) ? {Q_W{1'b1}} : num_ff[Q_W-1:0];
endmodule
